[src/rbpq_pkg.sv]
// Shared types and constants for the ring buffer priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rbpq_pkg;

    // Default geometry and fixed field widths.
    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_WIDTH    = 16;
    localparam int PRIO_WIDTH    = 8;

    // Request type codes.
    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Request word.
    typedef struct packed {
        logic                  req_type;
        logic [DATA_WIDTH-1:0] put_data;
        logic [PRIO_WIDTH-1:0] put_priority;
    } req_t;

    // Result word.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] get_data;
        status_t               status;
        logic                  is_empty;
        logic                  is_full;
    } rsp_t;

    // One stored queue entry.
    typedef struct packed {
        logic [PRIO_WIDTH-1:0] prio;
        logic [DATA_WIDTH-1:0] data;
    } entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_TAKE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic refuse;
        logic put;
        logic scan_start;
        logic scan;
        logic take;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_get;
        logic empty;
        logic full;
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

[src/ring_buffer_priority_queue.sv]
// Top level of the ring buffer priority queue: controller plus datapath.
// Depends on rbpq_pkg, rbpq_ctrl and rbpq_datapath.
//
// A request word is taken when start is high and busy is low. Its result word
// is on rsp when done is high for a single cycle, and rsp holds it until the
// next result; the receiver cannot stall it. A put, and any refused request,
// is decided in the decode state, which sets the done register. A get passes
// decode, scan and take; the scan reads one slot per cycle from the single read
// port of the entry memory. The next request may be accepted while done is high.
`default_nettype none

module ring_buffer_priority_queue #(
    parameter int DEPTH = rbpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire rbpq_pkg::req_t  req,
    output logic                 done,
    output rbpq_pkg::rsp_t       rsp
);
    import rbpq_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequencing of each request.
    rbpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .busy      (busy),
        .dp_cmd    (dp_cmd)
    );

    // Storage, scan and result register.
    rbpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .req_in    (req),
        .dp_status (dp_status),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[src/rbpq_ctrl.sv]
// Controller state machine of the ring buffer priority queue.
// Depends on rbpq_pkg for the state, command and status types.
`default_nettype none

module rbpq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire rbpq_pkg::dp_status_t dp_status,
    output logic                      busy,
    output rbpq_pkg::dp_cmd_t         dp_cmd
);
    import rbpq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (dp_status.req_get && !dp_status.empty)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (dp_status.scan_last)
                begin
                    state_next = ST_TAKE;
                end
            end
            ST_TAKE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: one command set per state.
    always_comb
    begin
        dp_cmd = '0;
        busy   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                dp_cmd.load = start;
            end
            ST_DECODE:
            begin
                if (dp_status.req_get)
                begin
                    dp_cmd.refuse     = dp_status.empty;
                    dp_cmd.scan_start = !dp_status.empty;
                end
                else
                begin
                    dp_cmd.refuse = dp_status.full;
                    dp_cmd.put    = !dp_status.full;
                end
            end
            ST_SCAN:
            begin
                dp_cmd.scan = 1'b1;
            end
            ST_TAKE:
            begin
                dp_cmd.take = 1'b1;
            end
            default:
            begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/rbpq_datapath.sv]
// Datapath of the ring buffer priority queue: entry memory, pointers, scan
// pipeline and result register. Depends on rbpq_pkg for its types.
`default_nettype none

module rbpq_datapath #(
    parameter int DEPTH = rbpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rbpq_pkg::dp_cmd_t    dp_cmd,
    input  wire rbpq_pkg::req_t       req_in,
    output rbpq_pkg::dp_status_t      dp_status,
    output logic                      done,
    output rbpq_pkg::rsp_t            rsp
);
    import rbpq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entry memory, one write and one registered read per cycle.
    entry_t         entry_mem_reg [DEPTH];
    entry_t         rd_entry_reg;
    logic           mem_we;
    logic [PW-1:0]  mem_waddr;
    entry_t         mem_wdata;

    // Control registers.
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]  issue_left_reg, issue_left_next;
    logic           issue_first_reg, issue_first_next;
    logic           rd_vld_reg, rd_vld_next;
    logic           rd_first_reg, rd_first_next;
    logic           done_reg, done_next;

    // Payload registers.
    req_t           req_reg, req_next;
    logic [PW-1:0]  rd_idx_reg, rd_idx_next;
    logic [PW-1:0]  best_idx_reg, best_idx_next;
    entry_t         best_entry_reg, best_entry_next;
    entry_t         head_entry_reg, head_entry_next;
    rsp_t           rsp_reg, rsp_next;

    // Next-state logic for every command.
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        scan_ptr_next    = scan_ptr_reg;
        issue_left_next  = issue_left_reg;
        issue_first_next = issue_first_reg;
        rd_vld_next      = 1'b0;
        rd_first_next    = rd_first_reg;
        rd_idx_next      = rd_idx_reg;
        done_next        = 1'b0;
        req_next         = req_reg;
        best_idx_next    = best_idx_reg;
        best_entry_next  = best_entry_reg;
        head_entry_next  = head_entry_reg;
        rsp_next         = rsp_reg;
        mem_we           = 1'b0;
        mem_waddr        = tail_reg;
        mem_wdata.prio   = req_reg.put_priority;
        mem_wdata.data   = req_reg.put_data;

        // Capture the request word.
        if (dp_cmd.load)
        begin
            req_next = req_in;
        end

        // Refused request: the queue does not change.
        if (dp_cmd.refuse)
        begin
            rsp_next.get_data = '0;
            rsp_next.status   = (req_reg.req_type == REQ_GET) ? STATUS_EMPTY : STATUS_FULL;
            done_next         = 1'b1;
        end

        // Put: write at the tail.
        if (dp_cmd.put)
        begin
            mem_we            = 1'b1;
            tail_next         = ptr_inc(tail_reg);
            count_next        = count_reg + 1'b1;
            rsp_next.get_data = '0;
            rsp_next.status   = STATUS_OK;
            done_next         = 1'b1;
        end

        // Scan setup: walk every stored entry from the head.
        if (dp_cmd.scan_start)
        begin
            scan_ptr_next    = head_reg;
            issue_left_next  = count_reg;
            issue_first_next = 1'b1;
        end

        // Scan read issue, one slot per cycle.
        if (dp_cmd.scan && (issue_left_reg != '0))
        begin
            rd_vld_next      = 1'b1;
            rd_idx_next      = scan_ptr_reg;
            rd_first_next    = issue_first_reg;
            issue_first_next = 1'b0;
            scan_ptr_next    = ptr_inc(scan_ptr_reg);
            issue_left_next  = issue_left_reg - 1'b1;
        end

        // Compare stage; strictly greater keeps the earliest entry on a tie.
        if (rd_vld_reg)
        begin
            if (rd_first_reg)
            begin
                best_entry_next = rd_entry_reg;
                best_idx_next   = rd_idx_reg;
                head_entry_next = rd_entry_reg;
            end
            else if (rd_entry_reg.prio > best_entry_reg.prio)
            begin
                best_entry_next = rd_entry_reg;
                best_idx_next   = rd_idx_reg;
            end
        end

        // Take: move the head entry into the winner's slot.
        if (dp_cmd.take)
        begin
            mem_we            = 1'b1;
            mem_waddr         = best_idx_reg;
            mem_wdata         = head_entry_reg;
            head_next         = ptr_inc(head_reg);
            count_next        = count_reg - 1'b1;
            rsp_next.get_data = best_entry_reg.data;
            rsp_next.status   = STATUS_OK;
            done_next         = 1'b1;
        end

        // Flags as they stand after the request.
        if (done_next)
        begin
            rsp_next.is_empty = (count_next == '0);
            rsp_next.is_full  = (count_next == CW'(DEPTH));
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            scan_ptr_reg    <= '0;
            issue_left_reg  <= '0;
            issue_first_reg <= 1'b0;
            rd_vld_reg      <= 1'b0;
            rd_first_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            scan_ptr_reg    <= scan_ptr_next;
            issue_left_reg  <= issue_left_next;
            issue_first_reg <= issue_first_next;
            rd_vld_reg      <= rd_vld_next;
            rd_first_reg    <= rd_first_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
        head_entry_reg <= head_entry_next;
        rsp_reg        <= rsp_next;
    end

    // Entry memory write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem_reg[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= entry_mem_reg[scan_ptr_reg];
    end

    // Status toward the controller and result outputs.
    assign dp_status.req_get   = (req_reg.req_type == REQ_GET);
    assign dp_status.empty     = (count_reg == '0);
    assign dp_status.full      = (count_reg == CW'(DEPTH));
    assign dp_status.scan_last = (issue_left_reg == '0);
    assign done                = done_reg;
    assign rsp                 = rsp_reg;

    // The entry count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // A result strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // A take only happens on a nonempty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.take |-> (count_reg != '0))
        else $error("take on an empty queue");

    // A put grows the entry count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.put |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("put did not grow the queue by one");

endmodule

`default_nettype wire
